[hdl/depth_pixel_backprojection_top_defines.svh]
// Assertion macros shared by the depth backprojection RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DEPTH_PIXEL_BACKPROJECTION_TOP_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define DPB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define DPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dpb_pkg.sv]
// Shared types, widths and constants for the depth backprojection block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpb_pkg;

    localparam int P_MAX_WIDTH  = 4096;
    localparam int P_MAX_HEIGHT = 4096;

    localparam int DEPTH_W  = 16;
    localparam int SIZE_W   = 13;
    localparam int MAXD_W   = 16;
    localparam int FOCAL_W  = 20;
    localparam int CENTER_W = 16;
    localparam int Z_W      = 20;
    localparam int COORD_W  = 32;

    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MAX_DEPTH    = 3'd2,
        REG_FOCAL_X      = 3'd3,
        REG_FOCAL_Y      = 3'd4,
        REG_CENTER_X     = 3'd5,
        REG_CENTER_Y     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0]   image_width;
        logic [SIZE_W-1:0]   image_height;
        logic [MAXD_W-1:0]   max_depth;
        logic [FOCAL_W-1:0]  focal_x;
        logic [FOCAL_W-1:0]  focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        image_width:  SIZE_W'(640),
        image_height: SIZE_W'(480),
        max_depth:    MAXD_W'(2000),
        focal_x:      FOCAL_W'(8400),
        focal_y:      FOCAL_W'(8400),
        center_x:     CENTER_W'(5112),
        center_y:     CENTER_W'(3832)
    };

    // per-pixel classification carried from front to back
    typedef struct packed {
        logic point_valid;
        logic frame_last;
    } t_pix_flags;

    // counter width for a dimension of n entries
    function automatic int f_cnt_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

[hdl/dpb_cfg_regs.sv]
// APB register file holding the camera and frame configuration.
// Depends on dpb_pkg.
`default_nettype none

module dpb_cfg_regs import dpb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[SIZE_W-1:0];
                REG_MAX_DEPTH:    n_cfg.max_depth    = pwdata[MAXD_W-1:0];
                REG_FOCAL_X:      n_cfg.focal_x      = pwdata[FOCAL_W-1:0];
                REG_FOCAL_Y:      n_cfg.focal_y      = pwdata[FOCAL_W-1:0];
                REG_CENTER_X:     n_cfg.center_x     = pwdata[CENTER_W-1:0];
                REG_CENTER_Y:     n_cfg.center_y     = pwdata[CENTER_W-1:0];
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg.image_height);
            REG_MAX_DEPTH:    prdata = APB_DW'(r_cfg.max_depth);
            REG_FOCAL_X:      prdata = APB_DW'(r_cfg.focal_x);
            REG_FOCAL_Y:      prdata = APB_DW'(r_cfg.focal_y);
            REG_CENTER_X:     prdata = APB_DW'(r_cfg.center_x);
            REG_CENTER_Y:     prdata = APB_DW'(r_cfg.center_y);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/dpb_front.sv]
// Front end: pixel intake, raster counters, classification, command queue.
// Depends on dpb_pkg.
`default_nettype none

module dpb_front import dpb_pkg::*; #(
    parameter int MAX_WIDTH  = P_MAX_WIDTH,
    parameter int MAX_HEIGHT = P_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cfg                              i_cfg,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [DEPTH_W-1:0]                i_depth_mm,
    output logic                              o_cmd_vld,
    input  logic                              i_cmd_take,
    output logic [f_cnt_w(MAX_WIDTH)-1:0]     o_cmd_col,
    output logic [f_cnt_w(MAX_HEIGHT)-1:0]    o_cmd_row,
    output logic [DEPTH_W-1:0]                o_cmd_depth,
    output t_pix_flags                        o_cmd_flags
);

    localparam int CW  = f_cnt_w(MAX_WIDTH);
    localparam int RW  = f_cnt_w(MAX_HEIGHT);
    localparam int SWX = (SIZE_W > $clog2(MAX_WIDTH + 1))  ? SIZE_W : $clog2(MAX_WIDTH + 1);
    localparam int SWY = (SIZE_W > $clog2(MAX_HEIGHT + 1)) ? SIZE_W : $clog2(MAX_HEIGHT + 1);
    localparam int QD  = 2;
    localparam int QPW = 1;

    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [SWX-1:0] w_eff;
    logic [SWY-1:0] h_eff;
    logic           row_end;
    logic           col_last;
    logic           pix_ok;
    logic           accept;
    logic           take;

    logic [CW-1:0]      r_q_col   [QD];
    logic [RW-1:0]      r_q_row   [QD];
    logic [DEPTH_W-1:0] r_q_depth [QD];
    t_pix_flags         r_q_flags [QD];
    logic [QPW-1:0]     r_wp;
    logic [QPW-1:0]     r_rp;
    logic [QPW:0]       r_cnt;
    logic [QPW:0]       n_cnt;

    // effective frame size: zero reads as one, oversize clamps to the maximum
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff = SWX'(1);
        end else if (SWX'(i_cfg.image_width) > SWX'(MAX_WIDTH)) begin
            w_eff = SWX'(MAX_WIDTH);
        end else begin
            w_eff = SWX'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h_eff = SWY'(1);
        end else if (SWY'(i_cfg.image_height) > SWY'(MAX_HEIGHT)) begin
            h_eff = SWY'(MAX_HEIGHT);
        end else begin
            h_eff = SWY'(i_cfg.image_height);
        end
    end

    assign row_end  = SWX'(r_col) >= (w_eff - SWX'(1));
    assign col_last = SWY'(r_row) >= (h_eff - SWY'(1));
    assign pix_ok   = (i_depth_mm != '0) && (i_depth_mm <= i_cfg.max_depth);

    assign o_full    = (r_cnt == (QPW+1)'(QD));
    assign o_cmd_vld = (r_cnt != '0);
    assign accept    = i_push && !o_full;
    assign take      = i_cmd_take && o_cmd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= col_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !take) begin
            n_cnt = r_cnt + (QPW+1)'(1);
        end else if (take && !accept) begin
            n_cnt = r_cnt - (QPW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (take) begin
                r_rp <= r_rp + QPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_col[r_wp]   <= r_col;
            r_q_row[r_wp]   <= r_row;
            r_q_depth[r_wp] <= i_depth_mm;
            r_q_flags[r_wp] <= '{point_valid: pix_ok, frame_last: row_end && col_last};
        end
    end

    assign o_cmd_col   = r_q_col[r_rp];
    assign o_cmd_row   = r_q_row[r_rp];
    assign o_cmd_depth = r_q_depth[r_rp];
    assign o_cmd_flags = r_q_flags[r_rp];

endmodule

`default_nettype wire

[hdl/dpb_div.sv]
// Bit-serial signed divider by an unsigned focal length, one quotient bit
// a cycle, truncating toward zero and saturating to 32 bits. Depends on dpb_pkg.
`default_nettype none

module dpb_div import dpb_pkg::*; #(
    parameter int NUM_W = 37
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [NUM_W-1:0]   i_num,
    input  logic [FOCAL_W-1:0]        i_den,
    output logic                      o_busy,
    output logic signed [COORD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] POS_LIM = {{(NUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic [NUM_W-1:0] NEG_LIM = {{(NUM_W-32){1'b0}}, 1'b1, {31{1'b0}}};

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_q;
    logic [FOCAL_W-1:0] r_rem;
    logic [FOCAL_W-1:0] r_den;
    logic               r_neg;
    logic [FOCAL_W:0]   trial;
    logic [FOCAL_W:0]   trial_sub;
    logic               ge;

    assign trial     = {r_rem, r_q[NUM_W-1]};
    assign ge        = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};
    assign o_busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_q   <= i_num[NUM_W-1] ? (NUM_W'(0) - i_num) : i_num;
            r_rem <= '0;
            r_den <= (i_den == '0) ? FOCAL_W'(1) : i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? trial_sub[FOCAL_W-1:0] : trial[FOCAL_W-1:0];
        end
    end

    // sign restore and saturation on the magnitude
    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q > POS_LIM) ? {1'b0, {(COORD_W-1){1'b1}}} : r_q[COORD_W-1:0];
        end else begin
            o_quot = (r_q > NEG_LIM) ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : (COORD_W'(0) - r_q[COORD_W-1:0]);
        end
    end

endmodule

`default_nettype wire

[hdl/dpb_back.sv]
// Back end: numerator multiply, two serial dividers, result queue.
// Depends on dpb_pkg, dpb_div and the assertion macro header.
`default_nettype none
`include "depth_pixel_backprojection_top_defines.svh"

module dpb_back import dpb_pkg::*; #(
    parameter int MAX_WIDTH  = P_MAX_WIDTH,
    parameter int MAX_HEIGHT = P_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_cmd_vld,
    output logic                           o_cmd_take,
    input  logic [f_cnt_w(MAX_WIDTH)-1:0]  i_cmd_col,
    input  logic [f_cnt_w(MAX_HEIGHT)-1:0] i_cmd_row,
    input  logic [DEPTH_W-1:0]             i_cmd_depth,
    input  t_pix_flags                     i_cmd_flags,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic signed [COORD_W-1:0]      o_x_pos,
    output logic signed [COORD_W-1:0]      o_y_pos,
    output logic [Z_W-1:0]                 o_z_pos,
    output logic                           o_point_valid,
    output logic                           o_frame_last
);

    localparam int CW  = f_cnt_w(MAX_WIDTH);
    localparam int RW  = f_cnt_w(MAX_HEIGHT);
    localparam int XW  = (CW + 4 > CENTER_W) ? CW + 4 : CENTER_W;
    localparam int YW  = (RW + 4 > CENTER_W) ? RW + 4 : CENTER_W;
    localparam int NXW = XW + 1 + Z_W;
    localparam int NYW = YW + 1 + Z_W;
    localparam int QD  = 2;
    localparam int QPW = 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [DEPTH_W-1:0]  r_depth;
    t_pix_flags          r_flags;
    logic signed [NXW-1:0] r_num_x;
    logic signed [NYW-1:0] r_num_y;

    logic [Z_W-1:0]             z16;
    logic signed [XW:0]         diff_x;
    logic signed [YW:0]         diff_y;
    logic signed [XW+Z_W+1:0]   prod_x;
    logic signed [YW+Z_W+1:0]   prod_y;
    logic                       div_start;
    logic                       busy_x;
    logic                       busy_y;
    logic signed [COORD_W-1:0]  quot_x;
    logic signed [COORD_W-1:0]  quot_y;
    logic                       push_res;
    logic                       pop_fire;

    logic signed [COORD_W-1:0] r_oq_x     [QD];
    logic signed [COORD_W-1:0] r_oq_y     [QD];
    logic [Z_W-1:0]            r_oq_z     [QD];
    t_pix_flags                r_oq_flags [QD];
    logic [QPW-1:0]            r_owp;
    logic [QPW-1:0]            r_orp;
    logic [QPW:0]              r_oq_cnt;
    logic [QPW:0]              n_oq_cnt;

    assign o_cmd_take = (r_state == ST_IDLE);

    // (pos*16 - center) * depth*16
    assign z16    = {r_depth, 4'b0000};
    assign diff_x = $signed({1'b0, XW'({r_col, 4'b0000})}) - $signed({1'b0, XW'(i_cfg.center_x)});
    assign diff_y = $signed({1'b0, YW'({r_row, 4'b0000})}) - $signed({1'b0, YW'(i_cfg.center_y)});
    assign prod_x = diff_x * $signed({1'b0, z16});
    assign prod_y = diff_y * $signed({1'b0, z16});

    assign div_start = (r_state == ST_START);
    assign push_res  = (r_state == ST_DONE) && (r_oq_cnt != (QPW+1)'(QD));
    assign pop_fire  = i_pop && !o_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_cmd_vld) n_state = ST_MUL;
            ST_MUL:   n_state = r_flags.point_valid ? ST_START : ST_DONE;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (!busy_x && !busy_y) n_state = ST_DONE;
            ST_DONE:  if (push_res) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_vld) begin
            r_col   <= i_cmd_col;
            r_row   <= i_cmd_row;
            r_depth <= i_cmd_depth;
            r_flags <= i_cmd_flags;
        end
        if (r_state == ST_MUL) begin
            r_num_x <= prod_x[NXW-1:0];
            r_num_y <= prod_y[NYW-1:0];
        end
    end

    dpb_div #(.NUM_W(NXW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num_x),
        .i_den   (i_cfg.focal_x),
        .o_busy  (busy_x),
        .o_quot  (quot_x)
    );

    dpb_div #(.NUM_W(NYW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num_y),
        .i_den   (i_cfg.focal_y),
        .o_busy  (busy_y),
        .o_quot  (quot_y)
    );

    // result queue
    always_comb begin
        n_oq_cnt = r_oq_cnt;
        if (push_res && !pop_fire) begin
            n_oq_cnt = r_oq_cnt + (QPW+1)'(1);
        end else if (pop_fire && !push_res) begin
            n_oq_cnt = r_oq_cnt - (QPW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp    <= '0;
            r_orp    <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_oq_cnt <= n_oq_cnt;
            if (push_res) begin
                r_owp <= r_owp + QPW'(1);
            end
            if (pop_fire) begin
                r_orp <= r_orp + QPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_res) begin
            r_oq_x[r_owp]     <= r_flags.point_valid ? quot_x : '0;
            r_oq_y[r_owp]     <= r_flags.point_valid ? quot_y : '0;
            r_oq_z[r_owp]     <= r_flags.point_valid ? z16 : '0;
            r_oq_flags[r_owp] <= r_flags;
        end
    end

    assign o_empty       = (r_oq_cnt == '0);
    assign o_x_pos       = r_oq_x[r_orp];
    assign o_y_pos       = r_oq_y[r_orp];
    assign o_z_pos       = r_oq_z[r_orp];
    assign o_point_valid = r_oq_flags[r_orp].point_valid;
    assign o_frame_last  = r_oq_flags[r_orp].frame_last;

    `DPB_ASSERT_IMPL(a_div_quiet, (r_state == ST_IDLE), (!busy_x && !busy_y), "divider busy while idle")
    `DPB_ASSERT_IMPL(a_inv_zero, (!o_empty && !o_point_valid), (o_x_pos == '0 && o_y_pos == '0 && o_z_pos == '0), "invalid point not zero")
    `DPB_ASSERT_IMPL(a_val_z, (!o_empty && o_point_valid), (o_z_pos != '0), "valid point with zero depth")
    `DPB_ASSERT_NEXT(a_push_cnt, (push_res && !pop_fire), (r_oq_cnt == $past(r_oq_cnt) + 2'd1), "result count did not grow")

endmodule

`default_nettype wire

[hdl/depth_pixel_backprojection_top.sv]
// Top level of the depth pixel backprojection block (pinhole model).
// Depends on dpb_pkg, dpb_cfg_regs, dpb_front, dpb_back.
//
//   channel   direction  handshake                 payload
//   pixel     in         push / full               i_depth_mm
//   point     out        empty / pop               o_x_pos o_y_pos o_z_pos
//                                                  o_point_valid o_frame_last
//   config    in/out     psel penable pwrite       paddr pwdata prdata
//                        pready (always 1)
//
// A valid pixel passes the back-end states idle, multiply, start, divide and
// done; divide lasts while the x and y bit-serial dividers run side by side
// through the NW-bit numerator (NW is 37 with the default maximum frame size).
// An invalid pixel skips start and divide. The front takes one pixel a cycle
// into a two-entry command queue while it is not full; the back drains it into
// a two-entry result queue, so either side stalls on its own.
// Reset is synchronous, active low, clears counters, state and queue pointers.
`default_nettype none

module depth_pixel_backprojection_top import dpb_pkg::*; #(
    parameter int MAX_WIDTH  = P_MAX_WIDTH,
    parameter int MAX_HEIGHT = P_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // pixel in
    input  logic                      push,
    output logic                      full,
    input  logic [DEPTH_W-1:0]        i_depth_mm,
    // point out
    output logic                      empty,
    input  logic                      pop,
    output logic signed [COORD_W-1:0] o_x_pos,
    output logic signed [COORD_W-1:0] o_y_pos,
    output logic [Z_W-1:0]            o_z_pos,
    output logic                      o_point_valid,
    output logic                      o_frame_last,
    // register access
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int CW = f_cnt_w(MAX_WIDTH);
    localparam int RW = f_cnt_w(MAX_HEIGHT);

    t_cfg               cfg;
    logic               cmd_vld;
    logic               cmd_take;
    logic [CW-1:0]      cmd_col;
    logic [RW-1:0]      cmd_row;
    logic [DEPTH_W-1:0] cmd_depth;
    t_pix_flags         cmd_flags;

    // configuration registers; the user must write them only while the datapath is idle, the block does not enforce it
    dpb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front: raster position, range check, end-of-frame flag
    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .o_full      (full),
        .i_depth_mm  (i_depth_mm),
        .o_cmd_vld   (cmd_vld),
        .i_cmd_take  (cmd_take),
        .o_cmd_col   (cmd_col),
        .o_cmd_row   (cmd_row),
        .o_cmd_depth (cmd_depth),
        .o_cmd_flags (cmd_flags)
    );

    // back: projection arithmetic and result buffering
    dpb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_vld     (cmd_vld),
        .o_cmd_take    (cmd_take),
        .i_cmd_col     (cmd_col),
        .i_cmd_row     (cmd_row),
        .i_cmd_depth   (cmd_depth),
        .i_cmd_flags   (cmd_flags),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_x_pos       (o_x_pos),
        .o_y_pos       (o_y_pos),
        .o_z_pos       (o_z_pos),
        .o_point_valid (o_point_valid),
        .o_frame_last  (o_frame_last)
    );

endmodule

`default_nettype wire
